// File: src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam int unsigned NumChain = 5;
  localparam int unsigned NumSched = 16;

  // initial chaining value
  localparam word_t IV [NumChain] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // round constants
  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [6:0] LastRound  = 7'd79;
  localparam logic [2:0] LastOutIdx = 3'd4;
  // schedule word positions inside a 16-word block
  localparam logic [4:0] LenHiWord  = 5'd14;
  localparam logic [4:0] LenLoWord  = 5'd15;
  localparam logic [4:0] BlockFull  = 5'd16;
  localparam logic [3:0] LenHiSlot  = 4'd14;

  // boolean function of the round
  function automatic word_t round_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // additive constant of the round
  function automatic word_t round_k(logic [6:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// File: src/sha1_stream_hash.sv
// ----------------------------------------------------------------------------
// sha1_stream_hash
// SHA-1 over a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request per message byte:
//   in_data_byte counts when in_byte_valid is high; in_last ends the message
//   (a valid byte on the same request is appended first). A request with
//   in_byte_valid low and in_last high ends an empty message.
//   Output channel (out_valid/out_ready) gives five digest words, word 0
//   first, out_word_last high on the fifth.
// Timing:
//   A byte that neither completes a 64-byte block nor ends the message leaves
//   in_ready high for the next byte. A byte that completes a block starts a
//   compression: the rounds on the single round unit and its 16-word schedule
//   shift line, then the add step. After last, padding shifts in 1 word per
//   cycle, then the rounds start, and again for an extra block when the
//   length needs one; each block is compressed as above, then the five words
//   are offered, one per cycle while out_ready is high. in_ready is low
//   during the compression after a byte that completes a block, and from
//   last until the fifth digest word is taken.
// Reset:
//   synchronous; restores the initial chaining value and a zero bit count.
//   A stalled receiver holds the current digest word until it is taken.
// ----------------------------------------------------------------------------
module sha1_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_word_last
);

  sha1_pkg::state_t state_r, state_nxt;

  sha1_pkg::word_t h_r [sha1_pkg::NumChain];
  sha1_pkg::word_t h_nxt [sha1_pkg::NumChain];
  sha1_pkg::word_t w_r [sha1_pkg::NumSched];
  sha1_pkg::word_t w_nxt [sha1_pkg::NumSched];
  sha1_pkg::word_t a_r, b_r, c_r, d_r, e_r;
  sha1_pkg::word_t a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [63:0] bit_cnt_r, bit_cnt_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [4:0]  wi_r, wi_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        mark_r, mark_nxt;
  logic        extra_r, extra_nxt;
  logic        pend_last_r, pend_last_nxt;

  logic            shift_en;
  sha1_pkg::word_t shift_val;
  sha1_pkg::word_t sched_new;
  sha1_pkg::word_t round_sum;
  logic [5:0]      pos;

  assign pos       = bit_cnt_r[8:3];
  assign in_ready  = (state_r == sha1_pkg::ST_IDLE);
  assign out_valid = (state_r == sha1_pkg::ST_OUT);
  assign out_digest_word = h_r[out_idx_r];
  assign out_word_last   = (out_idx_r == sha1_pkg::LastOutIdx);

  // round unit and schedule expansion
  assign sched_new = {w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]} << 1 |
                     {31'd0, w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};
  assign round_sum = {a_r[26:0], a_r[31:27]} + sha1_pkg::round_f(round_r, b_r, c_r, d_r)
                     + e_r + sha1_pkg::round_k(round_r) + w_r[0];

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    bit_cnt_nxt   = bit_cnt_r;
    round_nxt     = round_r;
    wi_nxt        = wi_r;
    out_idx_nxt   = out_idx_r;
    mark_nxt      = mark_r;
    extra_nxt     = extra_r;
    pend_last_nxt = pend_last_r;
    shift_en      = 1'b0;
    shift_val     = '0;

    case (state_r)
      sha1_pkg::ST_IDLE: begin
        mark_nxt  = 1'b0;
        extra_nxt = 1'b0;
        if (in_valid) begin
          if (in_byte_valid) begin
            acc_nxt     = {acc_r[23:0], in_data_byte};
            bit_cnt_nxt = bit_cnt_r + 64'd8;
            if (pos[1:0] == 2'd3) begin
              shift_en  = 1'b1;
              shift_val = {acc_r[23:0], in_data_byte};
            end
            if (pos == 6'd63) begin
              pend_last_nxt = in_last;
              state_nxt     = sha1_pkg::ST_ROUND;
              round_nxt     = '0;
              a_nxt = h_r[0]; b_nxt = h_r[1]; c_nxt = h_r[2];
              d_nxt = h_r[3]; e_nxt = h_r[4];
            end else if (in_last) begin
              state_nxt = sha1_pkg::ST_PAD;
            end
          end else if (in_last) begin
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end

      sha1_pkg::ST_PAD: begin
        if (!mark_r) begin
          // close the partial word with the 0x80 marker
          shift_en = 1'b1;
          case (bit_cnt_r[4:3])
            2'd0:    shift_val = {8'h80, 24'h0};
            2'd1:    shift_val = {acc_r[7:0], 8'h80, 16'h0};
            2'd2:    shift_val = {acc_r[15:0], 8'h80, 8'h0};
            2'd3:    shift_val = {acc_r[23:0], 8'h80};
            default: shift_val = '0;
          endcase
          mark_nxt  = 1'b1;
          wi_nxt    = {1'b0, bit_cnt_r[8:5]} + 5'd1;
          extra_nxt = (bit_cnt_r[8:5] >= sha1_pkg::LenHiSlot);
        end else if (wi_r == sha1_pkg::BlockFull) begin
          state_nxt = sha1_pkg::ST_ROUND;
          round_nxt = '0;
          a_nxt = h_r[0]; b_nxt = h_r[1]; c_nxt = h_r[2];
          d_nxt = h_r[3]; e_nxt = h_r[4];
        end else begin
          // zero fill, then the 64-bit length in the final two words of the last block
          shift_en  = 1'b1;
          shift_val = '0;
          if (!extra_r && wi_r == sha1_pkg::LenHiWord) begin
            shift_val = bit_cnt_r[63:32];
          end else if (!extra_r && wi_r == sha1_pkg::LenLoWord) begin
            shift_val = bit_cnt_r[31:0];
          end
          wi_nxt = wi_r + 5'd1;
        end
      end

      sha1_pkg::ST_ROUND: begin
        shift_en  = 1'b1;
        shift_val = sched_new;
        a_nxt = round_sum;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        if (round_r == sha1_pkg::LastRound) begin
          round_nxt = '0;
          state_nxt = sha1_pkg::ST_ADD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end

      sha1_pkg::ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (mark_r && !extra_r) begin
          out_idx_nxt = '0;
          state_nxt   = sha1_pkg::ST_OUT;
        end else if (mark_r) begin
          extra_nxt = 1'b0;
          wi_nxt    = '0;
          state_nxt = sha1_pkg::ST_PAD;
        end else if (pend_last_r) begin
          state_nxt = sha1_pkg::ST_PAD;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end

      sha1_pkg::ST_OUT: begin
        if (out_ready) begin
          if (out_idx_r == sha1_pkg::LastOutIdx) begin
            h_nxt         = sha1_pkg::IV;
            bit_cnt_nxt   = '0;
            mark_nxt      = 1'b0;
            pend_last_nxt = 1'b0;
            out_idx_nxt   = '0;
            state_nxt     = sha1_pkg::ST_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase

    // schedule shift line: entry 0 is the word used by the current round
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[15] = shift_val;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::ST_IDLE;
      h_r         <= sha1_pkg::IV;
      bit_cnt_r   <= '0;
      round_r     <= '0;
      wi_r        <= '0;
      out_idx_r   <= '0;
      mark_r      <= 1'b0;
      extra_r     <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      round_r     <= round_nxt;
      wi_r        <= wi_nxt;
      out_idx_r   <= out_idx_nxt;
      mark_r      <= mark_nxt;
      extra_r     <= extra_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    acc_r <= acc_nxt;
  end

  // round counter only runs inside compression
  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sha1_pkg::ST_ROUND) |-> (round_r == '0))
    else $error("round counter nonzero outside compression");

  // the two channels are never open at once
  a_chan_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest pending");

  // after the final word the hash restarts from the initial value
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_word_last) |=>
      (bit_cnt_r == '0 && h_r[0] == sha1_pkg::IV[0] && in_ready))
    else $error("hash state not reinitialized after digest");

  // padding never overruns a block
  a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wi_r <= sha1_pkg::BlockFull)
    else $error("padding word index out of range");

  // digest index only advances on a taken request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_idx_r)))
    else $error("digest word changed while stalled");

endmodule

// File: verif/sha1_stream_hash_test.sv
// ----------------------------------------------------------------------------
// sha1_stream_hash_test
// Self-checking bench for the SHA-1 stream hasher. Messages go in one byte
// request at a time; a local SHA-1 predictor works out the five digest words
// for each message end, and every word taken from the block is compared
// against the oldest predicted word. Known messages come first, then random
// traffic under four sender/receiver idling phases.
// ----------------------------------------------------------------------------
module sha1_stream_hash_test;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned NumWords    = 5;

  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte  = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_last       = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [31:0] out_digest_word;
  logic        out_word_last;

  // predictor state
  logic [31:0] hash_chain [NumWords];
  logic [7:0]  hash_block [64];
  logic [63:0] hash_bits;

  digest_word_t digest_q [$];
  digest_word_t want;

  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned requests_sent   = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;

  sha1_stream_hash dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_valid   (in_byte_valid),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_last   (out_word_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each taken digest word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t unexpected digest word: expected none, actual %h last %b",
                 $time, out_digest_word, out_word_last);
        error_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.word || out_word_last !== want.last) begin
          $display("%0t digest word mismatch: expected %h last %b, actual %h last %b",
                   $time, want.word, want.last, out_digest_word, out_word_last);
          error_count++;
        end
      end
    end
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic void init_chain();
    hash_chain[0] = 32'h67452301;
    hash_chain[1] = 32'hEFCDAB89;
    hash_chain[2] = 32'h98BADCFE;
    hash_chain[3] = 32'h10325476;
    hash_chain[4] = 32'hC3D2E1F0;
    hash_bits     = 64'd0;
  endfunction

  // 80-round compression of the buffered block into the chain
  function automatic void sha_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {hash_block[4 * i], hash_block[4 * i + 1],
              hash_block[4 * i + 2], hash_block[4 * i + 3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rotl(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  // fold one accepted request into the predictor, queue the digest on last
  function automatic void absorb_request(logic [7:0] data, logic bv, logic lst);
    int unsigned pos;
    logic [63:0] msg_bits;
    digest_word_t entry;
    if (bv) begin
      pos = 32'(hash_bits[8:3]);
      hash_block[pos] = data;
      hash_bits += 64'd8;
      if (pos == 63) sha_compress();
    end
    if (!lst) return;
    msg_bits = hash_bits;
    pos = 32'(hash_bits[8:3]);
    hash_block[pos] = 8'h80;
    pos++;
    // no room for the length: pad out and compress an extra block
    if (pos > 56) begin
      while (pos < 64) begin
        hash_block[pos] = 8'h00;
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < 56) begin
      hash_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) begin
      hash_block[56 + i] = 8'(msg_bits >> (56 - 8 * i));
    end
    sha_compress();
    for (int i = 0; i < NumWords; i++) begin
      entry.word = hash_chain[i];
      entry.last = (i == NumWords - 1);
      digest_q.push_back(entry);
    end
    init_chain();
  endfunction

  // present one request, hold it until taken, then predict
  task automatic send_request(logic [7:0] data, logic bv, logic lst);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_byte_valid <= bv;
    in_last       <= lst;
    do @(posedge clk); while (!in_ready);
    absorb_request(data, bv, lst);
    if (bv || lst) requests_sent++;
  endtask

  // drop valid and hold off until every predicted word has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // random message of len bytes with stray no-byte requests mixed in
  task automatic send_message(int unsigned len);
    logic end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(9) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(255)), 1'b1, end_on_byte && (n == len - 1));
    end
    if (!end_on_byte) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // empty message, short known strings, byte extremes, no-byte requests
  task automatic test_known_messages();
    sender_idle_pct = 0;
    stall_pct       = 0;
    send_request(8'h00, 1'b0, 1'b1);
    wait_drained();
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hA5, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h5A, 1'b0, 1'b1);
    wait_drained();
  endtask

  // random messages under one idling mix, optionally led by a long one
  task automatic test_random_messages(int unsigned idle, int unsigned stall,
                                      int unsigned long_len, int unsigned budget);
    int unsigned start;
    sender_idle_pct = idle;
    stall_pct       = stall;
    start           = requests_sent;
    if (long_len > 0) send_message(long_len);
    while (requests_sent - start < budget) send_message($urandom_range(0, 12));
  endtask

  initial begin
    init_chain();
    for (int i = 0; i < 64; i++) hash_block[i] = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_known_messages();
    // 56 bytes forces the extra padding block, 64 fills a block exactly
    test_random_messages(0, 0, 56, 45);
    test_random_messages(78, 0, 0, 15);
    test_random_messages(0, 78, 64, 45);
    test_random_messages(31, 31, 0, 15);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
src/sha1_pkg.sv
src/sha1_stream_hash.sv
verif/sha1_stream_hash_test.sv
